// ----- src/lz4d_pkg.sv -----
package lz4d_pkg;

    // input op codes (s_tuser)
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_START   = 2'd2;
    localparam logic [1:0] OP_ILLEGAL = 2'd3;

    // result kinds (m_tuser)
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_FINAL = 2'd1;
    localparam logic [1:0] KIND_ENDED = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_BAD_OFFSET = 2'd1;
    localparam logic [1:0] ERR_OVERRUN    = 2'd2;
    localparam logic [1:0] ERR_ORDER      = 2'd3;

    // one accepted transaction as seen by the history stage
    typedef struct packed {
        logic       vld;    // transaction yields a result
        logic       copy;   // data comes from history
        logic       write;  // byte goes into history
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] err;
    } lz4d_res_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [7:0] b);
        logic [32:0] s;
        s = {1'b0, a} + 33'(b);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ----- src/lz4d_parser.sv -----
module lz4d_parser
    import lz4d_pkg::*;
#(
    parameter int WINDOW_BYTES = 65536,
    localparam int AW = $clog2(WINDOW_BYTES)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [1:0]    op,
    input  logic [7:0]    in_byte,
    output lz4d_res_t     res,
    output logic [AW-1:0] rd_addr,
    output logic [AW-1:0] wr_addr
);

    localparam logic [3:0] PH_HDR0   = 4'd0;
    localparam logic [3:0] PH_HDR1   = 4'd1;
    localparam logic [3:0] PH_HDR2   = 4'd2;
    localparam logic [3:0] PH_HDR3   = 4'd3;
    localparam logic [3:0] PH_TOKEN  = 4'd4;
    localparam logic [3:0] PH_LITEXT = 4'd5;
    localparam logic [3:0] PH_LIT    = 4'd6;
    localparam logic [3:0] PH_OFFLO  = 4'd7;
    localparam logic [3:0] PH_OFFHI  = 4'd8;
    localparam logic [3:0] PH_MATEXT = 4'd9;
    localparam logic [3:0] PH_COPY   = 4'd10;
    localparam logic [3:0] PH_DONE   = 4'd11;
    localparam logic [3:0] PH_ERROR  = 4'd12;

    localparam logic [16:0] WIN = 17'(WINDOW_BYTES);

    logic [3:0]    phase_reg, phase_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [31:0]   produced_reg, produced_next;
    logic [31:0]   expected_reg, expected_next;
    logic [31:0]   lit_reg, lit_next;
    logic [31:0]   mat_reg, mat_next;
    logic [15:0]   off_reg, off_next;
    logic [3:0]    nib_reg, nib_next;

    logic [16:0]   wp_inc;
    logic [16:0]   rp_wide;
    logic [AW-1:0] wp_adv;

    always_comb
    begin
        wp_inc = 17'(wp_reg) + 17'd1;
        wp_adv = (wp_inc >= WIN) ? '0 : wp_inc[AW-1:0];
        if (17'(wp_reg) >= {1'b0, off_reg})
            rp_wide = 17'(wp_reg) - {1'b0, off_reg};
        else
            rp_wide = 17'(wp_reg) + WIN - {1'b0, off_reg};
        if (rp_wide >= WIN)
            rp_wide = '0;
    end

    assign rd_addr = rp_wide[AW-1:0];
    assign wr_addr = wp_reg;

    always_comb
    begin
        logic [31:0] room;
        logic [31:0] lit_cand;
        logic [31:0] mat_cand;
        logic [15:0] off_cand;
        logic        chk_lit;
        logic        chk_mat;
        logic        fail;
        logic [1:0]  fail_code;

        room      = expected_reg - produced_reg;
        lit_cand  = lit_reg;
        mat_cand  = mat_reg;
        off_cand  = {in_byte, off_reg[7:0]};
        chk_lit   = 1'b0;
        chk_mat   = 1'b0;
        fail      = 1'b0;
        fail_code = ERR_NONE;

        phase_next    = phase_reg;
        wp_next       = wp_reg;
        produced_next = produced_reg;
        expected_next = expected_reg;
        lit_next      = lit_reg;
        mat_next      = mat_reg;
        off_next      = off_reg;
        nib_next      = nib_reg;
        res           = '0;

        if (op == OP_START)
        begin
            produced_next = '0;
            expected_next = '0;
            lit_next      = '0;
            mat_next      = '0;
            off_next      = '0;
            nib_next      = '0;
            phase_next    = PH_HDR0;
        end
        else if (phase_reg == PH_ERROR)
        begin
            // dropped silently until a new block starts
        end
        else if (op == OP_ILLEGAL)
        begin
            fail      = 1'b1;
            fail_code = ERR_ORDER;
        end
        else if (op == OP_ADVANCE)
        begin
            if (phase_reg != PH_COPY)
            begin
                fail      = 1'b1;
                fail_code = ERR_ORDER;
            end
            else
            begin
                res.vld       = 1'b1;
                res.copy      = 1'b1;
                res.write     = 1'b1;
                res.kind      = KIND_DATA;
                wp_next       = wp_adv;
                produced_next = produced_reg + 32'd1;
                mat_next      = mat_reg - 32'd1;
                if (mat_reg == 32'd1)
                    phase_next = PH_TOKEN;
            end
        end
        else
        begin
            case (phase_reg)
                PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3:
                begin
                    expected_next = expected_reg | (32'(in_byte) << {phase_reg[1:0], 3'b000});
                    phase_next    = phase_reg + 4'd1;
                end
                PH_TOKEN:
                begin
                    nib_next = in_byte[3:0];
                    lit_cand = 32'(in_byte[7:4]);
                    lit_next = lit_cand;
                    if (in_byte[7:4] == 4'hF)
                        phase_next = PH_LITEXT;
                    else
                        chk_lit = 1'b1;
                end
                PH_LITEXT:
                begin
                    lit_cand = sat_add32(lit_reg, in_byte);
                    lit_next = lit_cand;
                    chk_lit  = (in_byte != 8'hFF);
                end
                PH_LIT:
                begin
                    res.vld       = 1'b1;
                    res.write     = 1'b1;
                    res.data      = in_byte;
                    res.kind      = KIND_DATA;
                    wp_next       = wp_adv;
                    produced_next = produced_reg + 32'd1;
                    lit_next      = lit_reg - 32'd1;
                    if (lit_reg == 32'd1)
                    begin
                        if (produced_reg + 32'd1 == expected_reg)
                        begin
                            phase_next = PH_DONE;
                            res.kind   = KIND_FINAL;
                        end
                        else
                            phase_next = PH_OFFLO;
                    end
                end
                PH_OFFLO:
                begin
                    off_next   = {8'd0, in_byte};
                    phase_next = PH_OFFHI;
                end
                PH_OFFHI:
                begin
                    off_next = off_cand;
                    if (off_cand == 16'd0 || {16'd0, off_cand} > produced_reg
                        || {1'b0, off_cand} > WIN)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_BAD_OFFSET;
                    end
                    else
                    begin
                        mat_cand = 32'(nib_reg) + 32'd4;
                        mat_next = mat_cand;
                        if (nib_reg == 4'hF)
                            phase_next = PH_MATEXT;
                        else
                            chk_mat = 1'b1;
                    end
                end
                PH_MATEXT:
                begin
                    mat_cand = sat_add32(mat_reg, in_byte);
                    mat_next = mat_cand;
                    chk_mat  = (in_byte != 8'hFF);
                end
                default:
                begin
                    // byte during copy, or after the block ended
                    fail      = 1'b1;
                    fail_code = ERR_ORDER;
                end
            endcase

            if (chk_lit)
            begin
                if (lit_cand > room)
                begin
                    fail      = 1'b1;
                    fail_code = ERR_OVERRUN;
                end
                else if (lit_cand != 32'd0)
                    phase_next = PH_LIT;
                else if (room == 32'd0)
                begin
                    phase_next = PH_DONE;
                    res.vld    = 1'b1;
                    res.kind   = KIND_ENDED;
                end
                else
                    phase_next = PH_OFFLO;
            end

            if (chk_mat)
            begin
                if (mat_cand > room)
                begin
                    fail      = 1'b1;
                    fail_code = ERR_OVERRUN;
                end
                else
                    phase_next = PH_COPY;
            end
        end

        if (fail)
        begin
            phase_next = PH_ERROR;
            res.vld    = 1'b1;
            res.copy   = 1'b0;
            res.write  = 1'b0;
            res.kind   = KIND_ERROR;
            res.data   = 8'd0;
            res.err    = fail_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            wp_reg       <= '0;
            produced_reg <= '0;
            expected_reg <= '0;
            lit_reg      <= '0;
            mat_reg      <= '0;
            off_reg      <= '0;
            nib_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            wp_reg       <= wp_next;
            produced_reg <= produced_next;
            expected_reg <= expected_next;
            lit_reg      <= lit_next;
            mat_reg      <= mat_next;
            off_reg      <= off_next;
            nib_reg      <= nib_next;
        end
    end

endmodule

// ----- src/lz4_block_decompressor_core.sv -----
// Channel  Dir  tdata                         tuser
// s_*      in   [7:0] in_byte                 [1:0] op
// m_*      out  [7:0] data_byte, [9:8] error  [1:0] kind
//
// One transaction per cycle in and out when m_tready stays high.
// A result reaches m_* through the history stage, which holds the synchronous read of the
// history memory, and then through the output register.
// A copy byte that reads the location written in the same cycle is forwarded.
// s_tready drops only while a result is held in the history stage and m_* is stalled.
// Reset clears the parser; history memory is not cleared (never read before written).
module lz4_block_decompressor_core
    import lz4d_pkg::*;
#(
    parameter int WINDOW_BYTES = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [9:8] error_code, rest zero
    output logic [1:0]  m_tuser    // [1:0] kind
);

    localparam int AW = $clog2(WINDOW_BYTES);

    logic          accept;
    lz4d_res_t     res;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    logic          s1_vld_reg;
    lz4d_res_t     s1_res_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_fwd_reg;
    logic [7:0]    s1_fwd_data_reg;
    logic [7:0]    rd_data_reg;
    logic [7:0]    s1_byte;
    logic          s1_move;

    logic          out_vld_reg;
    logic [1:0]    out_kind_reg;
    logic [7:0]    out_data_reg;
    logic [1:0]    out_err_reg;

    logic [7:0]    hist_mem [WINDOW_BYTES];

    assign accept   = s_tvalid && s_tready;
    assign s1_move  = s1_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !s1_vld_reg || s1_move;
    assign s1_byte  = s1_res_reg.copy ? (s1_fwd_reg ? s1_fwd_data_reg : rd_data_reg)
                                      : s1_res_reg.data;

    lz4d_parser #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .op      (s_tuser),
        .in_byte (s_tdata),
        .res     (res),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr)
    );

    // history: write-back of the stage-1 byte, read for a new copy
    always_ff @(posedge clk)
    begin
        if (s1_move && s1_res_reg.write)
            hist_mem[s1_addr_reg] <= s1_byte;
        if (accept && res.copy)
            rd_data_reg <= hist_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (accept && res.vld)
            s1_vld_reg <= 1'b1;
        else if (s1_move)
            s1_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && res.vld)
        begin
            s1_res_reg      <= res;
            s1_addr_reg     <= wr_addr;
            // memory returns the old byte when the read hits the location being written
            s1_fwd_reg      <= res.copy && s1_move && s1_res_reg.write
                               && (rd_addr == s1_addr_reg);
            s1_fwd_data_reg <= s1_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (s1_move)
            out_vld_reg <= 1'b1;
        else if (m_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_kind_reg <= s1_res_reg.kind;
            out_data_reg <= s1_byte;
            out_err_reg  <= s1_res_reg.err;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {6'd0, out_err_reg, out_data_reg};

`ifndef SYNTHESIS
    a_fwd_only_copy: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg && s1_fwd_reg |-> s1_res_reg.copy)
        else $error("forwarded byte on a non-copy transaction");

    a_copy_writes: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg && s1_res_reg.copy |-> s1_res_reg.write)
        else $error("copy byte not written back to history");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg && out_vld_reg && !m_tready |-> !s_tready)
        else $error("input taken while history stage is stalled");

    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> ((out_kind_reg == KIND_ERROR) == (out_err_reg != ERR_NONE)))
        else $error("error code does not match result kind");

    a_s1_drains: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && !accept |=> !s1_vld_reg)
        else $error("history stage kept a transaction it passed on");
`endif

endmodule

// ----- tb/sv/lz4_stream_checker.sv -----
`timescale 1ns / 100ps

module lz4_stream_checker
    import lz4d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          fail_count,
    output int          pending
);

    typedef enum logic [3:0] {
        P_HDR0, P_HDR1, P_HDR2, P_HDR3, P_TOKEN, P_LITEXT, P_LIT,
        P_OFFLO, P_OFFHI, P_MATEXT, P_COPY, P_DONE, P_ERROR
    } parse_phase_e;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] err;
    } decoded_t;

    logic [7:0]   hist [0:65535];
    logic [15:0]  wr_pos;
    logic [31:0]  produced;
    logic [31:0]  size_decl;
    logic [31:0]  lit_left;
    logic [31:0]  match_left;
    logic [15:0]  offset;
    logic [3:0]   match_nib;
    parse_phase_e phase;
    decoded_t     decoded_q[$];

    initial fail_count = 0;

    task automatic report_mismatch(string what, int got, int want);
        if (fail_count < 100)
            $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [7:0] b);
        return (a > 32'hFFFF_FFFF - 32'(b)) ? 32'hFFFF_FFFF : a + 32'(b);
    endfunction

    task automatic expect_out(logic [1:0] k, logic [7:0] d, logic [1:0] e);
        decoded_t r;
        r.kind = k;
        r.data = d;
        r.err  = e;
        decoded_q.push_back(r);
    endtask

    task automatic raise_error(logic [1:0] e);
        phase = P_ERROR;
        expect_out(KIND_ERROR, 8'h00, e);
    endtask

    task automatic put_history(logic [7:0] v);
        hist[wr_pos] = v;
        wr_pos = wr_pos + 16'd1;
        produced = produced + 32'd1;
    endtask

    task automatic literals_known();
        logic [31:0] room;
        room = size_decl - produced;
        if (lit_left > room)
            raise_error(ERR_OVERRUN);
        else if (lit_left != 0)
            phase = P_LIT;
        else if (room == 0)
        begin
            phase = P_DONE;
            expect_out(KIND_ENDED, 8'h00, ERR_NONE);
        end
        else
            phase = P_OFFLO;
    endtask

    task automatic match_known();
        if (match_left > size_decl - produced)
            raise_error(ERR_OVERRUN);
        else
            phase = P_COPY;
    endtask

    task automatic predict(logic [1:0] op, logic [7:0] b);
        logic [7:0] v;
        if (op == OP_START)
        begin
            produced   = '0;
            size_decl  = '0;
            lit_left   = '0;
            match_left = '0;
            offset     = '0;
            match_nib  = '0;
            phase      = P_HDR0;
        end
        else if (phase == P_ERROR)
        begin
            // everything but a new block is dropped silently
        end
        else if (op == OP_ILLEGAL)
            raise_error(ERR_ORDER);
        else if (op == OP_ADVANCE)
        begin
            if (phase != P_COPY)
                raise_error(ERR_ORDER);
            else
            begin
                // 16-bit subtract wraps round the window
                v = hist[wr_pos - offset];
                put_history(v);
                match_left = match_left - 32'd1;
                if (match_left == 0)
                    phase = P_TOKEN;
                expect_out(KIND_DATA, v, ERR_NONE);
            end
        end
        else
        begin
            case (phase)
                P_HDR0: begin size_decl[7:0]   = b; phase = P_HDR1; end
                P_HDR1: begin size_decl[15:8]  = b; phase = P_HDR2; end
                P_HDR2: begin size_decl[23:16] = b; phase = P_HDR3; end
                P_HDR3: begin size_decl[31:24] = b; phase = P_TOKEN; end
                P_TOKEN:
                begin
                    match_nib = b[3:0];
                    lit_left  = 32'(b[7:4]);
                    if (b[7:4] == 4'hF)
                        phase = P_LITEXT;
                    else
                        literals_known();
                end
                P_LITEXT:
                begin
                    lit_left = add_sat(lit_left, b);
                    if (b != 8'hFF)
                        literals_known();
                end
                P_LIT:
                begin
                    put_history(b);
                    lit_left = lit_left - 32'd1;
                    if (lit_left != 0)
                        expect_out(KIND_DATA, b, ERR_NONE);
                    else if (produced == size_decl)
                    begin
                        phase = P_DONE;
                        expect_out(KIND_FINAL, b, ERR_NONE);
                    end
                    else
                    begin
                        phase = P_OFFLO;
                        expect_out(KIND_DATA, b, ERR_NONE);
                    end
                end
                P_OFFLO: begin offset[7:0] = b; phase = P_OFFHI; end
                P_OFFHI:
                begin
                    offset[15:8] = b;
                    if (offset == 0 || 32'(offset) > produced)
                        raise_error(ERR_BAD_OFFSET);
                    else
                    begin
                        match_left = 32'(match_nib) + 32'd4;
                        if (match_nib == 4'hF)
                            phase = P_MATEXT;
                        else
                            match_known();
                    end
                end
                P_MATEXT:
                begin
                    match_left = add_sat(match_left, b);
                    if (b != 8'hFF)
                        match_known();
                end
                default: raise_error(ERR_ORDER);
            endcase
        end
    endtask

    task automatic check_result();
        decoded_t want;
        if (decoded_q.size() == 0)
            report_mismatch("unexpected result kind", m_tuser, 0);
        else
        begin
            want = decoded_q.pop_front();
            if (m_tuser != want.kind)
                report_mismatch("kind", m_tuser, want.kind);
            if (m_tdata[7:0] != want.data)
                report_mismatch("data_byte", m_tdata[7:0], want.data);
            if (m_tdata[9:8] != want.err)
                report_mismatch("error_code", m_tdata[9:8], want.err);
            if (m_tdata[15:10] != '0)
                report_mismatch("tdata padding", m_tdata[15:10], 0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos     = '0;
            produced   = '0;
            size_decl  = '0;
            lit_left   = '0;
            match_left = '0;
            offset     = '0;
            match_nib  = '0;
            phase      = P_HDR0;
            decoded_q.delete();
            pending   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                check_result();
            pending <= decoded_q.size();
        end
    end

endmodule

// ----- tb/sv/tb_lz4_block_decompressor_core.sv -----
`timescale 1ns / 100ps

module tb_lz4_block_decompressor_core;
    import lz4d_pkg::*;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] val;
    } stream_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] in_byte
    logic [1:0]  s_tuser;    // [1:0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [7:0] data_byte, [9:8] error_code
    logic [1:0]  m_tuser;    // [1:0] kind

    int           fail_count;
    int           pending;
    int           sent = 0;
    int           tx_idle_pct = 17;
    int           rx_idle_pct = 73;
    bit           pressure_armed = 1'b0;
    stream_item_t block_q[$];

    lz4_block_decompressor_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lz4_stream_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(10_000_000);
        $display("lz4_block_decompressor_core verification failed");
        $finish;
    end

    // sink side: random stalls plus one long hold-off to back up the pipeline
    initial
    begin
        int hold_left;
        bit pressure_used;
        hold_left     = 0;
        pressure_used = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_armed && !pressure_used)
            begin
                pressure_used = 1'b1;
                hold_left     = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic push(logic [1:0] op, logic [7:0] val);
        stream_item_t it;
        it.op  = op;
        it.val = val;
        block_q.push_back(it);
    endtask

    task automatic push_ext(int v);
        while (v >= 255)
        begin
            push(OP_BYTE, 8'hFF);
            v -= 255;
        end
        push(OP_BYTE, 8'(v));
    endtask

    function automatic logic [3:0] len_nibble(int n);
        return (n >= 15) ? 4'hF : 4'(n);
    endfunction

    task automatic send_item(stream_item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= it.val;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    task automatic send_block();
        foreach (block_q[i])
            send_item(block_q[i]);
        block_q.delete();
    endtask

    // one well-formed block with random content, sometimes damaged
    task automatic make_block();
        int          size;
        int          made;
        int          lit;
        int          rem;
        int          mlen;
        int          offs;
        int          roll;
        int          k;
        logic [31:0] hdr;
        logic [3:0]  mnib;
        stream_item_t it;

        roll = $urandom_range(99);
        if (roll < 5)
            size = 0;
        else if (roll < 12)
            size = $urandom_range(420, 200);
        else
            size = $urandom_range(40, 1);
        hdr = size;
        if ($urandom_range(99) < 4)
            hdr = $urandom;    // random declared size, almost always more than follows

        push(OP_START, 8'($urandom_range(255)));
        for (k = 0; k < 4; k++)
            push(OP_BYTE, hdr[8*k +: 8]);

        made = 0;
        if (size == 0)
            push(OP_BYTE, {4'h0, 4'($urandom_range(15))});
        while (made < size)
        begin
            if (size > 100 && $urandom_range(3) == 0)
                lit = $urandom_range(size - made, 0);
            else
                lit = $urandom_range((size - made < 20) ? size - made : 20, 0);
            if (made == 0 && lit == 0)
                lit = 1;
            rem = size - made - lit;
            if (rem > 0 && rem < 4)
            begin
                lit += rem;
                rem = 0;
            end
            mlen = 0;
            if (rem > 0)
            begin
                if ($urandom_range(9) == 0)
                    mlen = 4 + $urandom_range(rem - 4, 0);
                else
                    mlen = 4 + $urandom_range((rem - 4 < 24) ? rem - 4 : 24, 0);
                if (rem - mlen > 0 && rem - mlen < 4)
                    mlen = rem;
                mnib = len_nibble(mlen - 4);
            end
            else
                mnib = 4'($urandom_range(15));

            push(OP_BYTE, {len_nibble(lit), mnib});
            if (lit >= 15)
                push_ext(lit - 15);
            for (k = 0; k < lit; k++)
                push(OP_BYTE, 8'($urandom_range(255)));
            made += lit;

            if (rem > 0)
            begin
                // short offsets give overlapping copies
                if ($urandom_range(1) == 0)
                    offs = $urandom_range((made < 4) ? made : 4, 1);
                else
                    offs = $urandom_range(made, 1);
                if ($urandom_range(99) < 3)
                    offs = $urandom_range(1) ? 0 : $urandom_range(65535, made + 1);
                push(OP_BYTE, 8'(offs));
                push(OP_BYTE, 8'(offs >> 8));
                if (mlen - 4 >= 15)
                    push_ext(mlen - 19);
                for (k = 0; k < mlen; k++)
                    push(OP_ADVANCE, 8'($urandom_range(255)));
                made += mlen;
                // block closed by a match: needs a token with no literals
                if (made == size)
                    push(OP_BYTE, {4'h0, 4'($urandom_range(15))});
            end
        end

        if ($urandom_range(99) < 20)
        begin
            k = $urandom_range(block_q.size() - 1, 1);
            it.op  = 2'($urandom_range(3));
            it.val = 8'($urandom_range(255));
            case ($urandom_range(5))
                0: block_q[k] = it;
                1: block_q.insert(k, it);
                2: while (block_q.size() > k) void'(block_q.pop_back());
                3:
                begin
                    // trailing junk after the block has ended
                    repeat ($urandom_range(3, 1))
                        push(($urandom_range(1) == 0) ? OP_ILLEGAL : 2'($urandom_range(1)),
                             8'($urandom_range(255)));
                end
                4: block_q[1].val = block_q[1].val - 8'd1;
                default: void'(block_q.pop_front());
            endcase
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= OP_BYTE;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // size 5: one literal, overlapping copy of four, then empty final token
        push(OP_START, 8'h00);
        push(OP_BYTE, 8'h05); push(OP_BYTE, 8'h00); push(OP_BYTE, 8'h00); push(OP_BYTE, 8'h00);
        push(OP_BYTE, 8'h10); push(OP_BYTE, 8'hFF);
        push(OP_BYTE, 8'h01); push(OP_BYTE, 8'h00);
        repeat (4) push(OP_ADVANCE, 8'hFF);
        push(OP_BYTE, 8'h00);
        // advance after the end, then a new start with an illegal op and a byte ignored in error
        push(OP_ADVANCE, 8'h00);
        push(OP_START, 8'hFF);
        push(OP_ILLEGAL, 8'h00);
        push(OP_BYTE, 8'h00);
        // largest declared size, zero offset
        push(OP_START, 8'h00);
        repeat (4) push(OP_BYTE, 8'hFF);
        push(OP_BYTE, 8'h00);
        push(OP_BYTE, 8'h00); push(OP_BYTE, 8'h00);
        send_block();

        sent = 0;
        while (sent < 850)
        begin
            if (sent < 283)
            begin
                tx_idle_pct = 17;
                rx_idle_pct <= 73;
            end
            else if (sent < 566)
            begin
                tx_idle_pct = 73;
                rx_idle_pct <= 17;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
                pressure_armed <= 1'b1;
            end
            make_block();
            send_block();
        end
        s_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (12) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("lz4_block_decompressor_core verification clean");
        else
            $display("lz4_block_decompressor_core verification failed");
        $finish;
    end

endmodule
